// ===== rtl/core/csrf_pkg.sv =====
package csrf_pkg;

  localparam int CSRF_MAX_POINTS = 1024;
  localparam int CSRF_COORD_BITS = 12;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 11;

  localparam logic [CFG_IDX_BITS-1:0] CFG_CONTOUR_LENGTH     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ERROR_RUN      = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_LINE_DISTANCE  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EARLY_CHECK_OFFSET = 2'd3;

  localparam logic [10:0] RST_CONTOUR_LENGTH     = 11'd1024;
  localparam logic [7:0]  RST_MAX_ERROR_RUN      = 8'd35;
  localparam logic [5:0]  RST_MAX_LINE_DISTANCE  = 6'd2;
  localparam logic [9:0]  RST_EARLY_CHECK_OFFSET = 10'd5;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int MIN_CONTOUR_LENGTH = 3;
  localparam int RUN_START          = 2;

  // The bend test adds three copies of l1*l2 (four partial products each).
  localparam int BEND_ADD_UOPS = 12;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MOD,
    ST_RDP,
    ST_LATP,
    ST_DIR,
    ST_PROBE,
    ST_RDM,
    ST_LATM,
    ST_RDF,
    ST_LATF,
    ST_MAC,
    ST_POST,
    ST_JCHK,
    ST_RDQ,
    ST_LATQ,
    ST_QTEST,
    ST_UPD,
    ST_RDE,
    ST_LATE,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    PG_L1,
    PG_L2,
    PG_DOT,
    PG_BEND,
    PG_MD2,
    PG_TH,
    PG_N,
    PG_SQ,
    PG_END
  } prog_t;

endpackage

// ===== rtl/core/contour_straight_run_finder.sv =====
// Straight run finder over a closed contour held in an internal point memory.
// Input channel (in_valid / in_stall): op 0 stores one point at point_index,
// op 1 queries the straight runs backward and forward of point_index.
// A load gives no result. A query gives one result on the
// out_ channel (out_valid / out_stall): both run extents and the squared
// distances to the two run ends.
// The length of a query depends on the data: each direction runs a binary
// search of about log2(contour_length) probes. A probe of candidate length m
// runs the early bend check when m exceeds the early check offset and, if
// the bend is not too wide, tests the points on the run (a vertical line
// takes a shorter test). The query time is set by the single memory read
// port and the one shared 13x13 multiply-accumulate unit that every product
// of the query goes through.
// in_stall is high for the whole of a query. A finished result sits in the
// output register; the next transaction is taken while it waits, and a second
// result waits inside the block until the first has been taken.
// Configuration writes (cfg_valid / cfg_ready) are taken in any cycle and
// belong between transactions. Synchronous reset (rst_n low) returns the
// sequencer to idle, drops any pending result and restores the register
// defaults; the point memory is not cleared and must be loaded before use.
module contour_straight_run_finder
  import csrf_pkg::*;
#(
  parameter int MAX_POINTS = CSRF_MAX_POINTS,
  parameter int COORD_BITS = CSRF_COORD_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_op,
  input  logic [9:0]               in_point_index,
  input  logic [11:0]              in_coord_x,
  input  logic [11:0]              in_coord_y,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [9:0]               out_backward_extent,
  output logic [9:0]               out_forward_extent,
  output logic [24:0]              out_backward_sq_length,
  output logic [24:0]              out_forward_sq_length,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int CW  = COORD_BITS;
  localparam int IW  = $clog2(MAX_POINTS);
  localparam int LW  = $clog2(MAX_POINTS + 1);
  localparam int PIW = (LW > 10) ? LW : 10;
  localparam int U   = (CW + 1 > 12) ? CW + 1 : 12;
  localparam int AW  = 4 * U + 2;

  logic [CW-1:0] xmem [MAX_POINTS];
  logic [CW-1:0] ymem [MAX_POINTS];
  logic [CW-1:0] rdx_r, rdy_r;
  logic [IW-1:0] rd_addr;

  logic [10:0] len_cfg_r;
  logic [7:0]  mer_r;
  logic [5:0]  md_r;
  logic [9:0]  eco_r;

  state_t state_r, state_nxt;
  prog_t  prog_r, prog_nxt;
  logic [4:0] uc_r, uc_nxt;

  logic [PIW-1:0] idx_r, idx_nxt;
  logic [LW-1:0]  len_r, len_nxt, len_c;
  logic [IW-1:0]  p_r, p_nxt;
  logic           dir_r, dir_nxt;
  logic [LW-1:0]  s_r, s_nxt, e_r, e_nxt, m_r, m_nxt, j_r, j_nxt, line_r, line_nxt;
  logic [LW:0]    se_sum;
  logic [7:0]     err_r, err_nxt, high_r, high_nxt, err_inc, high_max;
  logic           off_r, off_nxt;

  logic [CW-1:0] px_r, px_nxt, py_r, py_nxt, mx_r, mx_nxt, my_r, my_nxt;
  logic [CW-1:0] fx_r, fx_nxt, fy_r, fy_nxt, qx_r, qx_nxt, qy_r, qy_nxt;

  logic [2*U-1:0] l1_r, l1_nxt, l2_r, l2_nxt, dot_r, dot_nxt, nmag_r, nmag_nxt;
  logic [11:0]    md2_r, md2_nxt;
  logic [3*U-1:0] th_r, th_nxt;
  logic [AW-1:0]  acc_r, acc_nxt, acc_sum, acc_base, shv, acc_mag;
  logic           acc_neg, acc_zero;

  logic [9:0]  sb_r, sb_nxt, sf_r, sf_nxt;
  logic [24:0] bsq_r, bsq_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [9:0]  ob_r, ob_nxt, of_r, of_nxt;
  logic [24:0] obsq_r, obsq_nxt, ofsq_r, ofsq_nxt;

  logic [U-1:0]   op_a, op_b;
  logic [1:0]     op_sh;
  logic           op_neg;
  logic [2*U-1:0] pv, pw, prod_c, prod_r;
  logic [1:0]     psh_r;
  logic           pneg_r, pfirst_r;

  logic [CW:0]   axd, ayd, bxd, byd, dxd, dyd;
  logic [CW-1:0] ax_m, ay_m, bx_m, by_m, dx_m, dy_m;

  function automatic logic [IW-1:0] step_idx(input logic [IW-1:0] p,
                                             input logic [LW-1:0] k,
                                             input logic back,
                                             input logic [LW-1:0] len);
    logic [LW:0] t;
    if (back) begin
      if ((LW+1)'(p) >= (LW+1)'(k)) begin
        t = (LW+1)'(p) - (LW+1)'(k);
      end else begin
        t = (LW+1)'(p) + (LW+1)'(len) - (LW+1)'(k);
      end
    end else begin
      t = (LW+1)'(p) + (LW+1)'(k);
      if (t >= (LW+1)'(len)) begin
        t = t - (LW+1)'(len);
      end
    end
    return IW'(t);
  endfunction

  function automatic logic [4:0] prog_len(input prog_t pg);
    logic [4:0] n;
    case (pg)
      PG_BEND: n = 5'(BEND_ADD_UOPS + 16);
      PG_SQ:   n = 5'd4;
      PG_MD2:  n = 5'd1;
      default: n = 5'd2;
    endcase
    return n;
  endfunction

  // Differences to P in sign and magnitude form.
  always_comb begin
    axd  = {1'b0, mx_r} - {1'b0, px_r};
    ayd  = {1'b0, my_r} - {1'b0, py_r};
    bxd  = {1'b0, fx_r} - {1'b0, px_r};
    byd  = {1'b0, fy_r} - {1'b0, py_r};
    dxd  = {1'b0, qx_r} - {1'b0, px_r};
    dyd  = {1'b0, qy_r} - {1'b0, py_r};
    ax_m = axd[CW] ? CW'(-axd) : CW'(axd);
    ay_m = ayd[CW] ? CW'(-ayd) : CW'(ayd);
    bx_m = bxd[CW] ? CW'(-bxd) : CW'(bxd);
    by_m = byd[CW] ? CW'(-byd) : CW'(byd);
    dx_m = dxd[CW] ? CW'(-dxd) : CW'(dxd);
    dy_m = dyd[CW] ? CW'(-dyd) : CW'(dyd);
  end

  // Operand selection for the shared multiplier. Wide products are split into
  // partial products (four, or two for md2 times l1); uc_r[1:0] picks the halves and the shift.
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sh  = 2'd0;
    op_neg = 1'b0;
    pv     = nmag_r;
    pw     = nmag_r;
    case (prog_r)
      PG_L1: begin
        op_a = uc_r[0] ? U'(ay_m) : U'(ax_m);
        op_b = op_a;
      end
      PG_L2: begin
        op_a = uc_r[0] ? U'(by_m) : U'(bx_m);
        op_b = op_a;
      end
      PG_DOT: begin
        op_a   = uc_r[0] ? U'(ay_m) : U'(ax_m);
        op_b   = uc_r[0] ? U'(by_m) : U'(bx_m);
        op_neg = uc_r[0] ? (ayd[CW] ^ byd[CW]) : (axd[CW] ^ bxd[CW]);
      end
      PG_MD2: begin
        op_a = U'(md_r);
        op_b = U'(md_r);
      end
      PG_TH: begin
        op_a  = U'(md2_r);
        op_b  = uc_r[0] ? l1_r[2*U-1:U] : l1_r[U-1:0];
        op_sh = {1'b0, uc_r[0]};
      end
      PG_N: begin
        op_a   = uc_r[0] ? U'(ax_m) : U'(ay_m);
        op_b   = uc_r[0] ? U'(dy_m) : U'(dx_m);
        op_neg = uc_r[0] ? !(axd[CW] ^ dyd[CW]) : (ayd[CW] ^ dxd[CW]);
      end
      PG_END: begin
        op_a = uc_r[0] ? U'(dy_m) : U'(dx_m);
        op_b = op_a;
      end
      PG_BEND, PG_SQ: begin
        if (prog_r == PG_BEND) begin
          if (uc_r < 5'(BEND_ADD_UOPS)) begin
            pv = l1_r;
            pw = l2_r;
          end else begin
            pv     = dot_r;
            pw     = dot_r;
            op_neg = 1'b1;
          end
        end
        op_a  = uc_r[1] ? pv[2*U-1:U] : pv[U-1:0];
        op_b  = uc_r[0] ? pw[2*U-1:U] : pw[U-1:0];
        op_sh = {uc_r[1] & uc_r[0], uc_r[1] ^ uc_r[0]};
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  assign prod_c = op_a * op_b;

  always_comb begin
    case (psh_r)
      2'd0:    shv = AW'(prod_r);
      2'd1:    shv = AW'(prod_r) << U;
      default: shv = AW'(prod_r) << (2 * U);
    endcase
    acc_base = pfirst_r ? '0 : acc_r;
    acc_sum  = pneg_r ? (acc_base - shv) : (acc_base + shv);
    acc_neg  = acc_r[AW-1];
    acc_zero = (acc_r == '0);
    acc_mag  = acc_neg ? -acc_r : acc_r;
  end

  always_comb begin
    if (32'(len_cfg_r) < MIN_CONTOUR_LENGTH) begin
      len_c = LW'(MIN_CONTOUR_LENGTH);
    end else if (32'(len_cfg_r) > MAX_POINTS) begin
      len_c = LW'(MAX_POINTS);
    end else begin
      len_c = LW'(len_cfg_r);
    end
  end

  always_comb begin
    case (state_r)
      ST_RDM:  rd_addr = step_idx(p_r, m_r, dir_r, len_r);
      ST_RDF:  rd_addr = step_idx(p_r, LW'(eco_r), dir_r, len_r);
      ST_RDQ:  rd_addr = step_idx(p_r, j_r, dir_r, len_r);
      ST_RDE:  rd_addr = step_idx(p_r, s_r, dir_r, len_r);
      default: rd_addr = p_r;
    endcase
  end

  assign se_sum   = (LW+1)'(s_r) + (LW+1)'(e_r);
  assign err_inc  = err_r + 8'd1;
  assign high_max = (high_r < err_r) ? err_r : high_r;

  always_comb begin
    state_nxt     = state_r;
    prog_nxt      = prog_r;
    uc_nxt        = uc_r;
    idx_nxt       = idx_r;
    len_nxt       = len_r;
    p_nxt         = p_r;
    dir_nxt       = dir_r;
    s_nxt         = s_r;
    e_nxt         = e_r;
    m_nxt         = m_r;
    j_nxt         = j_r;
    line_nxt      = line_r;
    err_nxt       = err_r;
    high_nxt      = high_r;
    off_nxt       = off_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    fx_nxt        = fx_r;
    fy_nxt        = fy_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    l1_nxt        = l1_r;
    l2_nxt        = l2_r;
    dot_nxt       = dot_r;
    nmag_nxt      = nmag_r;
    md2_nxt       = md2_r;
    th_nxt        = th_r;
    acc_nxt       = acc_r;
    sb_nxt        = sb_r;
    sf_nxt        = sf_r;
    bsq_nxt       = bsq_r;
    ob_nxt        = ob_r;
    of_nxt        = of_r;
    obsq_nxt      = obsq_r;
    ofsq_nxt      = ofsq_r;
    out_valid_nxt = out_valid_r & out_stall;

    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_op == OP_QUERY) begin
          idx_nxt   = PIW'(in_point_index);
          len_nxt   = len_c;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        if (idx_r >= PIW'(len_r)) begin
          idx_nxt = idx_r - PIW'(len_r);
        end else begin
          p_nxt     = IW'(idx_r);
          state_nxt = ST_RDP;
        end
      end
      ST_RDP: state_nxt = ST_LATP;
      ST_LATP: begin
        px_nxt    = rdx_r;
        py_nxt    = rdy_r;
        dir_nxt   = 1'b1;
        state_nxt = ST_DIR;
      end
      ST_DIR: begin
        s_nxt     = LW'(RUN_START);
        e_nxt     = len_r;
        state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        if (e_r - s_r > LW'(1)) begin
          m_nxt     = se_sum[LW:1];
          state_nxt = ST_RDM;
        end else begin
          state_nxt = ST_RDE;
        end
      end
      ST_RDM: state_nxt = ST_LATM;
      ST_LATM: begin
        mx_nxt    = rdx_r;
        my_nxt    = rdy_r;
        prog_nxt  = PG_L1;
        uc_nxt    = '0;
        state_nxt = ST_MAC;
      end
      ST_RDF: state_nxt = ST_LATF;
      ST_LATF: begin
        fx_nxt    = rdx_r;
        fy_nxt    = rdy_r;
        prog_nxt  = PG_L2;
        uc_nxt    = '0;
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        uc_nxt = uc_r + 5'd1;
        if (uc_r != '0) begin
          acc_nxt = acc_sum;
        end
        if (uc_r == prog_len(prog_r)) begin
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        uc_nxt    = '0;
        state_nxt = ST_MAC;
        case (prog_r)
          PG_L1: begin
            l1_nxt = acc_r[2*U-1:0];
            if (32'(m_r) > 32'(eco_r)) begin
              state_nxt = ST_RDF;
            end else begin
              prog_nxt = PG_MD2;
            end
          end
          PG_L2: begin
            l2_nxt   = acc_r[2*U-1:0];
            prog_nxt = PG_DOT;
          end
          PG_DOT: begin
            dot_nxt = acc_r[2*U-1:0];
            if (l1_r == '0 || l2_r == '0) begin
              prog_nxt = PG_MD2;
            end else if (acc_neg || acc_zero) begin
              e_nxt     = m_r;
              state_nxt = ST_PROBE;
            end else begin
              prog_nxt = PG_BEND;
            end
          end
          PG_BEND: begin
            // 3*l1*l2 - 4*dot^2 > 0 means the angle is wider than 30 degrees.
            if (!acc_neg && !acc_zero) begin
              e_nxt     = m_r;
              state_nxt = ST_PROBE;
            end else begin
              prog_nxt = PG_MD2;
            end
          end
          PG_MD2: begin
            md2_nxt  = acc_r[11:0];
            prog_nxt = PG_TH;
          end
          PG_TH: begin
            th_nxt    = acc_r[3*U-1:0];
            j_nxt     = LW'(1);
            err_nxt   = '0;
            high_nxt  = '0;
            line_nxt  = '0;
            state_nxt = ST_JCHK;
          end
          PG_N: begin
            nmag_nxt = acc_mag[2*U-1:0];
            prog_nxt = PG_SQ;
          end
          PG_SQ: begin
            off_nxt   = (acc_r > AW'(th_r));
            state_nxt = ST_UPD;
          end
          PG_END: begin
            if (dir_r) begin
              sb_nxt    = 10'(s_r);
              bsq_nxt   = acc_r[24:0];
              dir_nxt   = 1'b0;
              state_nxt = ST_DIR;
            end else begin
              sf_nxt    = 10'(s_r);
              state_nxt = ST_DONE;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_JCHK: begin
        if (j_r < m_r) begin
          state_nxt = ST_RDQ;
        end else begin
          if (high_r == '0) begin
            s_nxt = m_r;
          end else begin
            e_nxt = m_r;
          end
          state_nxt = ST_PROBE;
        end
      end
      ST_RDQ: state_nxt = ST_LATQ;
      ST_LATQ: begin
        qx_nxt    = rdx_r;
        qy_nxt    = rdy_r;
        state_nxt = ST_QTEST;
      end
      ST_QTEST: begin
        // A vertical line (P and M share x) is tested on x distance alone.
        if (axd == '0) begin
          off_nxt   = (dx_m > CW'(md_r)) || (CW < 6 && (32'(dx_m) > 32'(md_r)));
          state_nxt = ST_UPD;
        end else begin
          prog_nxt  = PG_N;
          uc_nxt    = '0;
          state_nxt = ST_MAC;
        end
      end
      ST_UPD: begin
        j_nxt     = j_r + LW'(1);
        state_nxt = ST_JCHK;
        if (off_r) begin
          line_nxt = '0;
          err_nxt  = err_inc;
          if (err_inc >= mer_r) begin
            e_nxt     = m_r;
            state_nxt = ST_PROBE;
          end
        end else begin
          err_nxt  = '0;
          line_nxt = line_r + LW'(1);
          if (32'(line_r) + 32'd1 >= 32'(high_max >> 1)) begin
            high_nxt = '0;
          end else begin
            high_nxt = high_max;
          end
        end
      end
      ST_RDE: state_nxt = ST_LATE;
      ST_LATE: begin
        qx_nxt    = rdx_r;
        qy_nxt    = rdy_r;
        prog_nxt  = PG_END;
        uc_nxt    = '0;
        state_nxt = ST_MAC;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          ob_nxt        = sb_r;
          of_nxt        = sf_r;
          obsq_nxt      = bsq_r;
          ofsq_nxt      = acc_r[24:0];
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid && in_op == OP_LOAD &&
        32'(in_point_index) < MAX_POINTS) begin
      xmem[IW'(in_point_index)] <= CW'(in_coord_x);
      ymem[IW'(in_point_index)] <= CW'(in_coord_y);
    end
    rdx_r <= xmem[rd_addr];
    rdy_r <= ymem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      len_cfg_r   <= RST_CONTOUR_LENGTH;
      mer_r       <= RST_MAX_ERROR_RUN;
      md_r        <= RST_MAX_LINE_DISTANCE;
      eco_r       <= RST_EARLY_CHECK_OFFSET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CONTOUR_LENGTH:     len_cfg_r <= cfg_data;
          CFG_MAX_ERROR_RUN:      mer_r     <= cfg_data[7:0];
          CFG_MAX_LINE_DISTANCE:  md_r      <= cfg_data[5:0];
          CFG_EARLY_CHECK_OFFSET: eco_r     <= cfg_data[9:0];
          default:                mer_r     <= mer_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    prog_r   <= prog_nxt;
    uc_r     <= uc_nxt;
    idx_r    <= idx_nxt;
    len_r    <= len_nxt;
    p_r      <= p_nxt;
    dir_r    <= dir_nxt;
    s_r      <= s_nxt;
    e_r      <= e_nxt;
    m_r      <= m_nxt;
    j_r      <= j_nxt;
    line_r   <= line_nxt;
    err_r    <= err_nxt;
    high_r   <= high_nxt;
    off_r    <= off_nxt;
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    mx_r     <= mx_nxt;
    my_r     <= my_nxt;
    fx_r     <= fx_nxt;
    fy_r     <= fy_nxt;
    qx_r     <= qx_nxt;
    qy_r     <= qy_nxt;
    l1_r     <= l1_nxt;
    l2_r     <= l2_nxt;
    dot_r    <= dot_nxt;
    nmag_r   <= nmag_nxt;
    md2_r    <= md2_nxt;
    th_r     <= th_nxt;
    acc_r    <= acc_nxt;
    sb_r     <= sb_nxt;
    sf_r     <= sf_nxt;
    bsq_r    <= bsq_nxt;
    ob_r     <= ob_nxt;
    of_r     <= of_nxt;
    obsq_r   <= obsq_nxt;
    ofsq_r   <= ofsq_nxt;
    prod_r   <= prod_c;
    psh_r    <= op_sh;
    pneg_r   <= op_neg;
    pfirst_r <= (uc_r == '0);
  end

  assign in_stall               = (state_r != ST_IDLE);
  assign cfg_ready              = 1'b1;
  assign out_valid              = out_valid_r;
  assign out_backward_extent    = ob_r;
  assign out_forward_extent     = of_r;
  assign out_backward_sq_length = obsq_r;
  assign out_forward_sq_length  = ofsq_r;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import csrf_pkg::*;

  typedef struct packed {
    logic [9:0]  bwd_ext;
    logic [9:0]  fwd_ext;
    logic [24:0] bwd_sq;
    logic [24:0] fwd_sq;
  } run_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_op;
  logic [9:0]               in_point_index;
  logic [11:0]              in_coord_x;
  logic [11:0]              in_coord_y;
  logic                     out_valid;
  logic                     out_stall;
  logic [9:0]               out_backward_extent;
  logic [9:0]               out_forward_extent;
  logic [24:0]              out_backward_sq_length;
  logic [24:0]              out_forward_sq_length;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  contour_straight_run_finder uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_point_index(in_point_index), .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_backward_extent(out_backward_extent), .out_forward_extent(out_forward_extent),
    .out_backward_sq_length(out_backward_sq_length),
    .out_forward_sq_length(out_forward_sq_length),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state.
  longint      pt_x [CSRF_MAX_POINTS];
  longint      pt_y [CSRF_MAX_POINTS];
  int unsigned cur_len;
  int unsigned cur_max_err;
  int unsigned cur_max_dist;
  int unsigned cur_check_off;

  run_result_t run_expect_q [$];
  int          err_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  bit          rx_take;
  run_result_t rx_seen;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int unsigned walk_index(int unsigned p, int unsigned k, bit back,
                                             int unsigned len);
    return back ? (p + len - k) % len : (p + k) % len;
  endfunction

  // Angle at P between M and F is wider than thirty degrees.
  function automatic bit bend_too_wide(longint px, longint py, longint mx, longint my,
                                       longint fx, longint fy);
    longint     ax, ay, bx, by, dot;
    bit [63:0]  l1, l2, d2;
    ax = mx - px; ay = my - py; bx = fx - px; by = fy - py;
    l1 = ax * ax + ay * ay;
    l2 = bx * bx + by * by;
    dot = ax * bx + ay * by;
    if (l1 == 0 || l2 == 0) return 1'b0;
    if (dot <= 0) return 1'b1;
    d2 = dot * 2;
    return (l1 * 3 * l2) > (d2 * d2);
  endfunction

  function automatic int unsigned straight_run(int unsigned p, bit back, int unsigned len);
    longint      px, py, mx, my, ca, cd, qx, qy, nv;
    bit [63:0]   thr, nsq, md;
    int unsigned s, e, m, mi, fi, q, j, errs, high, line;
    bit          ok, off;
    px = pt_x[p]; py = pt_y[p];
    s = RUN_START; e = len;
    while (e - s > 1) begin
      m = (s + e) / 2;
      mi = walk_index(p, m, back, len);
      mx = pt_x[mi]; my = pt_y[mi];
      if (m > cur_check_off) begin
        fi = walk_index(p, cur_check_off, back, len);
        if (bend_too_wide(px, py, mx, my, pt_x[fi], pt_y[fi])) begin
          e = m;
          continue;
        end
      end
      ca = my - py; cd = px - mx;
      md = cur_max_dist;
      thr = md * md * (ca * ca + cd * cd);
      errs = 0; high = 0; line = 0; ok = 1'b1;
      for (j = 1; j < m; j++) begin
        q = walk_index(p, j, back, len);
        qx = pt_x[q]; qy = pt_y[q];
        if (cd == 0) begin
          nv = qx - px;
          if (nv < 0) nv = -nv;
          off = nv > md;
        end else begin
          nv = ca * (qx - px) + cd * (qy - py);
          if (nv < 0) nv = -nv;
          nsq = nv * nv;
          off = nsq > thr;
        end
        if (off) begin
          line = 0;
          errs++;
          if (errs >= cur_max_err) begin
            ok = 1'b0;
            break;
          end
        end else begin
          if (high < errs) high = errs;
          errs = 0;
          line++;
          if (line >= high / 2) high = 0;
        end
      end
      if (ok && high == 0) s = m;
      else e = m;
    end
    return s;
  endfunction

  function automatic logic [24:0] sq_dist(int unsigned a, int unsigned b);
    longint dx, dy;
    dx = pt_x[a] - pt_x[b];
    dy = pt_y[a] - pt_y[b];
    return 25'(dx * dx + dy * dy);
  endfunction

  function automatic void predict_runs(logic op, logic [9:0] idx, logic [11:0] x,
                                       logic [11:0] y);
    int unsigned len, p, sb, sf;
    run_result_t r;
    if (op == OP_LOAD) begin
      pt_x[idx] = x;
      pt_y[idx] = y;
      return;
    end
    len = cur_len;
    if (len < MIN_CONTOUR_LENGTH) len = MIN_CONTOUR_LENGTH;
    if (len > CSRF_MAX_POINTS) len = CSRF_MAX_POINTS;
    p = idx % len;
    sb = straight_run(p, 1'b1, len);
    sf = straight_run(p, 1'b0, len);
    r.bwd_ext = 10'(sb);
    r.fwd_ext = 10'(sf);
    r.bwd_sq = sq_dist(p, walk_index(p, sb, 1'b1, len));
    r.fwd_sq = sq_dist(p, walk_index(p, sf, 1'b0, len));
    run_expect_q.push_back(r);
  endfunction

  // Result side: sample at the falling edge, the transaction completes at the next rise.
  always @(negedge clk) begin
    rx_take = out_valid && !out_stall;
    rx_seen = '{out_backward_extent, out_forward_extent,
                out_backward_sq_length, out_forward_sq_length};
  end

  always @(posedge clk) begin
    run_result_t exp_r;
    if (rx_take) begin
      if (run_expect_q.size() == 0) begin
        $error("result with no query pending");
        err_count++;
      end else begin
        exp_r = run_expect_q.pop_front();
        if (rx_seen.bwd_ext !== exp_r.bwd_ext) begin
          $error("backward_extent: expected %0d, got %0d", exp_r.bwd_ext, rx_seen.bwd_ext);
          err_count++;
        end
        if (rx_seen.fwd_ext !== exp_r.fwd_ext) begin
          $error("forward_extent: expected %0d, got %0d", exp_r.fwd_ext, rx_seen.fwd_ext);
          err_count++;
        end
        if (rx_seen.bwd_sq !== exp_r.bwd_sq) begin
          $error("backward_sq_length: expected %0d, got %0d", exp_r.bwd_sq, rx_seen.bwd_sq);
          err_count++;
        end
        if (rx_seen.fwd_sq !== exp_r.fwd_sq) begin
          $error("forward_sq_length: expected %0d, got %0d", exp_r.fwd_sq, rx_seen.fwd_sq);
          err_count++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Called at a rising edge; returns at the edge where the transaction was taken.
  task automatic send_item(logic op, logic [9:0] idx, logic [11:0] x, logic [11:0] y);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_point_index <= idx;
    in_coord_x     <= x;
    in_coord_y     <= y;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    predict_runs(op, idx, x, y);
  endtask

  task automatic query_at(int unsigned idx);
    send_item(OP_QUERY, 10'(idx), 12'($urandom), 12'($urandom));
  endtask

  // Waits until every query has answered, then lets a trailing load settle.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (run_expect_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_BITS'(value);
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    case (idx)
      CFG_CONTOUR_LENGTH:     cur_len       = value & 11'h7ff;
      CFG_MAX_ERROR_RUN:      cur_max_err   = value & 8'hff;
      CFG_MAX_LINE_DISTANCE:  cur_max_dist  = value & 6'h3f;
      CFG_EARLY_CHECK_OFFSET: cur_check_off = value & 10'h3ff;
      default: ;
    endcase
  endtask

  task automatic set_regs(int unsigned len, int unsigned merr, int unsigned mdist,
                          int unsigned coff);
    wait_all_results();
    write_reg(CFG_CONTOUR_LENGTH, len);
    write_reg(CFG_MAX_ERROR_RUN, merr);
    write_reg(CFG_MAX_LINE_DISTANCE, mdist);
    write_reg(CFG_EARLY_CHECK_OFFSET, coff);
    cfg_valid <= 1'b0;
  endtask

  // Loads points 0..n-1 as a few noisy straight segments, or as scattered points.
  task automatic load_contour(int unsigned n);
    int x, y, dx, dy, seg_left, noise, i;
    bit scatter;
    scatter = ($urandom_range(4) == 0);
    x = $urandom_range(4095); y = $urandom_range(4095);
    noise = $urandom_range(3);
    seg_left = 0; dx = 0; dy = 0;
    for (i = 0; i < n; i++) begin
      if (scatter) begin
        x = $urandom_range(4095); y = $urandom_range(4095);
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(2, 12);
          dx = $urandom_range(400) - 200;
          dy = $urandom_range(400) - 200;
        end
        seg_left--;
        x = x + dx + $urandom_range(2 * noise) - noise;
        y = y + dy + $urandom_range(2 * noise) - noise;
        if (x < 0) x = 0;
        if (x > 4095) x = 4095;
        if (y < 0) y = 0;
        if (y > 4095) y = 4095;
      end
      send_item(OP_LOAD, 10'(i), 12'(x), 12'(y));
    end
  endtask

  task automatic test_tiny_contour();
    set_regs(3, 35, 2, 5);
    send_item(OP_LOAD, 10'd0, 12'd0, 12'd0);
    send_item(OP_LOAD, 10'd1, 12'd4095, 12'd4095);
    send_item(OP_LOAD, 10'd2, 12'd0, 12'd4095);
    query_at(0);
    query_at(2);
    query_at(1023);
    // A zero length register is clamped to the shortest contour.
    set_regs(0, 35, 2, 5);
    query_at(1);
  endtask

  task automatic test_vertical_and_coincident();
    int i;
    // Zero error run, zero distance and a zero check offset at once.
    set_regs(8, 0, 0, 0);
    for (i = 0; i < 8; i++)
      send_item(OP_LOAD, 10'(i), 12'd100, (i % 3 == 0) ? 12'd500 : 12'(500 + i));
    query_at(0);
    query_at(5);
    set_regs(8, 1, 1, 2);
    query_at(3);
  endtask

  task automatic test_config_extremes();
    set_regs(12, 255, 63, 1023);
    load_contour(12);
    query_at(4);
    set_regs(12, 1, 63, 1);
    query_at(11);
  endtask

  task automatic test_random_queries(int rounds);
    int r, k, nq;
    int unsigned len;
    for (r = 0; r < rounds; r++) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(3, 48) : $urandom_range(3, 20);
      set_regs(len,
               ($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(1, 8),
               ($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(4),
               ($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(1, 8));
      load_contour(len);
      nq = $urandom_range(1, 4);
      for (k = 0; k < nq; k++) begin
        // Occasionally rewrite a point already in the contour.
        if ($urandom_range(4) == 0)
          send_item(OP_LOAD, 10'($urandom_range(len - 1)), 12'($urandom), 12'($urandom));
        if (k == 1 && r % 3 == 0) wait_all_results();
        query_at($urandom_range(1023));
      end
    end
  endtask

  task automatic test_long_contour();
    set_regs(16, 1, 2, 5);
    load_contour(16);
    query_at($urandom_range(1023));
    // The same contour under the default error run and distance.
    set_regs(16, 35, 2, 5);
    query_at($urandom_range(1023));
  endtask

  initial begin
    err_count      = 0;
    send_idle_pct  = 21;
    recv_stall_pct = 88;
    cur_len        = RST_CONTOUR_LENGTH;
    cur_max_err    = RST_MAX_ERROR_RUN;
    cur_max_dist   = RST_MAX_LINE_DISTANCE;
    cur_check_off  = RST_EARLY_CHECK_OFFSET;
    foreach (pt_x[i]) begin
      pt_x[i] = 0;
      pt_y[i] = 0;
    end
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_op          <= OP_LOAD;
    in_point_index <= '0;
    in_coord_x     <= '0;
    in_coord_y     <= '0;
    out_stall      <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_tiny_contour();
    test_vertical_and_coincident();
    test_config_extremes();
    test_random_queries(2);
    send_idle_pct  = 88;
    recv_stall_pct = 21;
    test_random_queries(2);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_queries(2);
    test_long_contour();

    wait_all_results();
    repeat (50) @(posedge clk);
    if (err_count == 0) begin
      $display("** contour_straight_run_finder: PASSED **");
    end else begin
      $display("** contour_straight_run_finder: FAILED **");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("** contour_straight_run_finder: FAILED **");
    $finish;
  end

endmodule
